### design/mbtp_pkg.sv
// shared types and constants for the modbus tcp field parser
package mbtp_pkg;
  localparam int unsigned HdrBytes = 7;
  localparam logic [8:0] PosMax = 9'd511;

  typedef enum logic [2:0] {
    KIND_FUNC  = 3'd0,
    KIND_EXC   = 3'd1,
    KIND_COUNT = 3'd2,
    KIND_REG   = 3'd3,
    KIND_ADDR  = 3'd4,
    KIND_QTY   = 3'd5,
    KIND_VALUE = 3'd6
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic [15:0] flow_tag;
  } in_t;

  typedef struct packed {
    logic [2:0]  record_kind;
    logic [15:0] field_value;
    logic [16:0] register_address;
    logic [15:0] transaction_id;
    logic        is_response;
  } out_t;

  // control given to every cell of the row
  typedef struct packed {
    logic        lookup;    // search and erase on hit
    logic        insert;    // place into first free cell
    logic [15:0] flow;
    logic [15:0] tid;
    logic [15:0] start;
  } cell_req_t;

  typedef struct packed {
    logic        hit;       // lookup already matched upstream
    logic        placed;    // insert already made upstream
    logic [15:0] start;
  } cell_res_t;
endpackage

### design/mbtp_if.sv
// valid/ready channel interface
interface mbtp_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/mbtp_cell.sv
// one entry of the pending request table
module mbtp_cell import mbtp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_req_t req_i,
  input  cell_res_t res_i,
  output cell_res_t res_o
);
  logic        valid_q;
  logic [15:0] flow_q, tid_q, start_q;
  logic hit, place;

  assign hit   = req_i.lookup && !res_i.hit && valid_q &&
                 flow_q == req_i.flow && tid_q == req_i.tid;
  assign place = req_i.insert && !res_i.placed && !valid_q;

  always_comb begin
    res_o = res_i;
    if (hit) begin
      res_o.hit   = 1'b1;
      res_o.start = start_q;
    end
    if (place) res_o.placed = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (hit) begin
      valid_q <= 1'b0;
    end else if (place) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (place) begin
      flow_q  <= req_i.flow;
      tid_q   <= req_i.tid;
      start_q <= req_i.start;
    end
  end
endmodule

### design/modbus_tcp_pdu_field_parser_core.sv
// top level of the modbus tcp pdu field parser
// usage:
//   in_i carries one payload byte per request with first/last marks and the
//   flow tag; out_o carries one field record whenever a field completes.
//   a byte is taken every cycle while the output register is free or being
//   drained, so throughput is one byte per cycle.
//   a record is registered: it appears on out_o in the cycle after the byte that completes it.
//   the pending table is a row of TABLE_ENTRIES cells; the function code
//   byte runs a lookup through the row, lowest index wins, a hit erases the
//   entry; the last byte of a request places an entry in the first free
//   cell, dropped when all are full. both complete within the byte's cycle.
//   reset clears the parse state and all valid bits of the table.
//   when the receiver stalls with a record held, bytes keep flowing if they
//   make no record; a byte that would make a record waits until the held
//   one is taken.
module modbus_tcp_pdu_field_parser_core import mbtp_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  mbtp_if.sink   in_i,
  mbtp_if.source out_o
);
  in_t  b;
  assign b = in_i.data;

  logic [8:0]  pos_q, pos_d;
  logic [15:0] tid_q, tid_d;
  logic [7:0]  func_q, func_d;
  logic        resp_q, resp_d;
  logic [15:0] mstart_q, mstart_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  high_q, high_d;
  logic [15:0] cstart_q, cstart_d;
  logic        ovalid_q;
  out_t        odata_q;

  logic [8:0]  pos, d;
  logic [15:0] word;
  logic        emit;
  out_t        rec;
  logic        is_rw, is_rd, accept;
  logic [7:0]  k, i;
  logic        do_ins;

  cell_req_t req;
  cell_res_t chain [TABLE_ENTRIES+1];

  assign pos   = b.first_byte ? 9'd0 : pos_q;
  assign d     = pos - 9'(HdrBytes + 1);
  assign word  = {high_q, b.data_byte};
  assign k     = 8'(d - 9'd1);
  assign i     = {1'b0, k[7:1]};
  assign is_rd = func_q >= 8'd1 && func_q <= 8'd4;
  assign is_rw = (func_q >= 8'd1 && func_q <= 8'd6) || func_q == 8'd15 ||
                 func_q == 8'd16;

  // row of table cells
  assign req.lookup = accept && pos == 9'(HdrBytes);
  assign req.insert = do_ins;
  assign req.flow   = b.flow_tag;
  assign req.tid    = tid_q;
  assign req.start  = (is_rw && pos >= 9'(HdrBytes + 3)) ? cstart_q : 16'd0;
  assign chain[0]   = '0;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    mbtp_cell u_cell (
      .clk_i, .rst_ni, .req_i(req), .res_i(chain[g]), .res_o(chain[g+1])
    );
  end

  always_comb begin
    emit = 1'b0;
    rec  = '0;
    tid_d = tid_q; func_d = func_q; resp_d = resp_q; mstart_d = mstart_q;
    count_d = count_q; high_d = high_q; cstart_d = cstart_q;
    rec.transaction_id = tid_q;
    rec.is_response = resp_q;
    if (pos < 9'd2) begin
      tid_d = {tid_q[7:0], b.data_byte};
    end else if (pos == 9'(HdrBytes)) begin
      func_d  = b.data_byte;
      count_d = 8'd0;
      resp_d  = chain[TABLE_ENTRIES].hit;
      mstart_d = chain[TABLE_ENTRIES].hit ? chain[TABLE_ENTRIES].start : 16'd0;
      emit = 1'b1;
      rec.record_kind = KIND_FUNC;
      rec.field_value = {9'd0, b.data_byte[6:0]};
      rec.is_response = chain[TABLE_ENTRIES].hit;
    end else if (pos > 9'(HdrBytes)) begin
      if (d == 9'd1) cstart_d = word;
      if (func_q > 8'h80) begin
        if (d == 9'd0) begin
          emit = 1'b1;
          rec.record_kind = KIND_EXC;
          rec.field_value = {8'd0, b.data_byte};
        end
      end else if (is_rd && resp_q) begin
        if (d == 9'd0) begin
          count_d = b.data_byte;
          emit = 1'b1;
          rec.record_kind = KIND_COUNT;
          rec.field_value = {8'd0, b.data_byte};
        end else if (d <= 9'd256 && i < {1'b0, count_q[7:1]}) begin
          if (!k[0]) begin
            high_d = b.data_byte;
          end else begin
            emit = 1'b1;
            rec.record_kind = KIND_REG;
            rec.field_value = word;
            rec.register_address = {1'b0, mstart_q} + {9'd0, i};
          end
        end
      end else if (is_rw) begin
        unique case (d)
          9'd0, 9'd2: high_d = b.data_byte;
          9'd1: begin
            emit = 1'b1;
            rec.record_kind = KIND_ADDR;
            rec.field_value = word;
          end
          9'd3: begin
            emit = 1'b1;
            rec.record_kind = (func_q == 8'd5 || func_q == 8'd6) ? KIND_VALUE : KIND_QTY;
            rec.field_value = word;
          end
          9'd4: begin
            if ((func_q == 8'd15 || func_q == 8'd16) && !resp_q) begin
              emit = 1'b1;
              rec.record_kind = KIND_COUNT;
              rec.field_value = {8'd0, b.data_byte};
            end
          end
          default: ;
        endcase
      end
    end
    if (b.last_byte) pos_d = 9'd0;
    else if (pos < PosMax) pos_d = pos + 9'd1;
    else pos_d = pos;
  end

  // insert uses the response flag as updated by this byte
  assign do_ins = accept && b.last_byte && pos >= 9'(HdrBytes) && !resp_d;

  assign in_i.ready = !ovalid_q || out_o.ready || !emit;
  assign accept = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; tid_q <= '0; func_q <= '0; resp_q <= 1'b0; mstart_q <= '0;
      count_q <= '0; high_q <= '0; cstart_q <= '0; ovalid_q <= 1'b0;
    end else begin
      if (accept) begin
        pos_q <= pos_d; tid_q <= tid_d; func_q <= func_d; resp_q <= resp_d;
        mstart_q <= mstart_d; count_q <= count_d; high_q <= high_d;
        cstart_q <= cstart_d;
      end
      if (accept && emit) ovalid_q <= 1'b1;
      else if (out_o.ready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) odata_q <= rec;
  end

  assign out_o.valid = ovalid_q;
  assign out_o.data  = odata_q;
endmodule

### bench/tb.sv
// testbench for the modbus tcp pdu field parser: random packets against a field predictor
module tb import mbtp_pkg::*; ();
  localparam int unsigned WATCHDOG_LIMIT = 5000;

  logic clk_i;
  logic rst_ni;

  mbtp_if #(.T(in_t))  in_if ();
  mbtp_if #(.T(out_t)) out_if ();

  modbus_tcp_pdu_field_parser_core #(.TABLE_ENTRIES(16)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // parser state mirror
  logic [8:0]  pos_q;
  logic [15:0] tid_q;
  logic [7:0]  func_q;
  logic        resp_q;
  logic [15:0] mstart_q;
  logic [7:0]  count_q;
  logic [7:0]  held_q;
  logic [15:0] cap_q;
  logic        pend_valid [16];
  logic [15:0] pend_flow  [16];
  logic [15:0] pend_tid   [16];
  logic [15:0] pend_start [16];

  out_t        field_q [$];
  logic [7:0]  pkt_q [$];
  int unsigned errors;
  int unsigned items_sent;
  int unsigned idle_cycles;
  bit          steady;

  // open request bookkeeping for building well-formed responses
  logic [15:0] open_flow [$];
  logic [15:0] open_tid  [$];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic void push_field(input kind_e kind, input logic [15:0] value,
                                     input logic [16:0] addr);
    out_t rec;
    rec.record_kind      = kind;
    rec.field_value      = value;
    rec.register_address = addr;
    rec.transaction_id   = tid_q;
    rec.is_response      = resp_q;
    field_q.push_back(rec);
  endfunction

  function automatic bit has_addr_fields(input logic [7:0] f);
    return (f >= 8'd1 && f <= 8'd6) || f == 8'd15 || f == 8'd16;
  endfunction

  function automatic void parse_pdu(input int d, input logic [7:0] b);
    logic [15:0] word;
    int k;
    int i;
    word = {held_q, b};
    if (d == 1) cap_q = word;
    if (func_q > 8'h80) begin
      if (d == 0) push_field(KIND_EXC, {8'h00, b}, '0);
    end else if (func_q >= 8'd1 && func_q <= 8'd4 && resp_q) begin
      if (d == 0) begin
        count_q = b;
        push_field(KIND_COUNT, {8'h00, b}, '0);
      end else begin
        k = d - 1;
        i = k >> 1;
        if (i < int'(count_q >> 1)) begin
          if ((k & 1) == 0) held_q = b;
          else push_field(KIND_REG, word, 17'(mstart_q) + 17'(i));
        end
      end
    end else if (has_addr_fields(func_q)) begin
      if (d == 0 || d == 2) held_q = b;
      else if (d == 1) push_field(KIND_ADDR, word, '0);
      else if (d == 3)
        push_field((func_q == 8'd5 || func_q == 8'd6) ? KIND_VALUE : KIND_QTY, word, '0);
      else if (d == 4 && (func_q == 8'd15 || func_q == 8'd16) && !resp_q)
        push_field(KIND_COUNT, {8'h00, b}, '0);
    end
  endfunction

  // advances the mirror by one byte and queues the field it completes
  function automatic void predict_fields(input in_t req);
    logic [8:0] p;
    logic [15:0] start;
    bit placed;
    if (req.first_byte) pos_q = '0;
    p = pos_q;
    if (p < 9'd2) begin
      tid_q = {tid_q[7:0], req.data_byte};
    end else if (p == 9'(HdrBytes)) begin
      func_q  = req.data_byte;
      count_q = '0;
      resp_q  = 1'b0;
      mstart_q = '0;
      for (int e = 0; e < 16; e++) begin
        if (!resp_q && pend_valid[e] && pend_flow[e] == req.flow_tag && pend_tid[e] == tid_q)
        begin
          resp_q = 1'b1;
          mstart_q = pend_start[e];
          pend_valid[e] = 1'b0;
        end
      end
      push_field(KIND_FUNC, {9'h000, req.data_byte[6:0]}, '0);
    end else if (p > 9'(HdrBytes)) begin
      parse_pdu(int'(p) - HdrBytes - 1, req.data_byte);
    end
    if (req.last_byte) begin
      if (p >= 9'(HdrBytes) && !resp_q) begin
        start = (has_addr_fields(func_q) && p >= 9'(HdrBytes + 3)) ? cap_q : 16'h0000;
        placed = 1'b0;
        for (int e = 0; e < 16; e++) begin
          if (!placed && !pend_valid[e]) begin
            pend_valid[e] = 1'b1;
            pend_flow[e]  = req.flow_tag;
            pend_tid[e]   = tid_q;
            pend_start[e] = start;
            placed = 1'b1;
          end
        end
      end
      pos_q = '0;
    end else if (p < PosMax) begin
      pos_q = p + 9'd1;
    end
  endfunction

  // sends one byte, keeping valid high when no gap follows
  task automatic send_byte(input in_t req);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= req;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_fields(req);
    items_sent++;
  endtask

  // sends pkt_q as one packet; drop_last leaves it open
  task automatic send_packet(input logic [15:0] flow, input bit drop_last = 1'b0);
    in_t req;
    for (int n = 0; n < pkt_q.size(); n++) begin
      req.data_byte  = pkt_q[n];
      req.first_byte = (n == 0);
      req.last_byte  = (n == pkt_q.size() - 1) && !drop_last;
      req.flow_tag   = flow;
      send_byte(req);
    end
  endtask

  // header plus function code; pdu bytes are appended by the caller
  task automatic start_packet(input logic [15:0] tid, input logic [7:0] f);
    pkt_q.delete();
    pkt_q.push_back(tid[15:8]);
    pkt_q.push_back(tid[7:0]);
    repeat (5) pkt_q.push_back(8'($urandom));
    pkt_q.push_back(f);
  endtask

  task automatic add_bytes(input int n);
    repeat (n) pkt_q.push_back(8'($urandom));
  endtask

  task automatic send_request(input logic [15:0] flow, input logic [15:0] tid);
    logic [7:0] f;
    case ($urandom_range(0, 7))
      0, 1, 2, 3: f = 8'($urandom_range(1, 4));
      4, 5:       f = 8'($urandom_range(5, 6));
      default:    f = ($urandom_range(0, 1) != 0) ? 8'd15 : 8'd16;
    endcase
    start_packet(tid, f);
    add_bytes((f >= 8'd15) ? $urandom_range(5, 9) : 4);
    send_packet(flow);
    open_flow.push_back(flow);
    open_tid.push_back(tid);
  endtask

  task automatic send_response(input int slot);
    logic [7:0] cnt;
    logic [15:0] flow;
    logic [15:0] tid;
    flow = open_flow[slot];
    tid  = open_tid[slot];
    open_flow.delete(slot);
    open_tid.delete(slot);
    if ($urandom_range(0, 5) == 0) begin
      start_packet(tid, 8'($urandom_range(8'h81, 8'hff)));
      add_bytes(1);
    end else begin
      cnt = 8'($urandom_range(0, 12));
      start_packet(tid, 8'($urandom_range(1, 4)));
      pkt_q.push_back(cnt);
      add_bytes(cnt + $urandom_range(0, 2));
    end
    send_packet(flow);
  endtask

  task automatic drain_fields();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (field_q.size() != 0) @(posedge clk_i);
  endtask

  // receiver: per record a random stall, sometimes none
  initial begin
    int unsigned stall;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!(out_if.valid && out_if.ready)) @(posedge clk_i);
    end
  end

  // record checker
  always @(posedge clk_i) begin
    out_t got;
    out_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (field_q.size() == 0) begin
        report($sformatf("unexpected record kind %0d value %h", got.record_kind,
                         got.field_value));
      end else begin
        want = field_q.pop_front();
        if (got.record_kind != want.record_kind)
          report($sformatf("kind %0d, want %0d", got.record_kind, want.record_kind));
        if (got.field_value != want.field_value)
          report($sformatf("value %h, want %h", got.field_value, want.field_value));
        if (got.register_address != want.register_address)
          report($sformatf("address %h, want %h", got.register_address,
                           want.register_address));
        if (got.transaction_id != want.transaction_id)
          report($sformatf("tid %h, want %h", got.transaction_id, want.transaction_id));
        if (got.is_response != want.is_response)
          report($sformatf("response %b, want %b", got.is_response, want.is_response));
      end
    end
  end

  // watchdog on cycles with no accepted request or record
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic test_function_codes();
    // every function code class, exceptions and the 0x80 edge
    start_packet(16'h0000, 8'h03); add_bytes(4); send_packet(16'h0000);
    start_packet(16'h0000, 8'h03); pkt_q.push_back(8'd4);
    pkt_q.push_back(8'hff); pkt_q.push_back(8'hff);
    pkt_q.push_back(8'h00); pkt_q.push_back(8'h01); send_packet(16'h0000);
    start_packet(16'hffff, 8'h06); add_bytes(4); send_packet(16'hffff);
    start_packet(16'hffff, 8'h10); add_bytes(7); send_packet(16'hffff);
    start_packet(16'h1234, 8'h80); add_bytes(2); send_packet(16'h0001);
    start_packet(16'h1235, 8'hff); add_bytes(2); send_packet(16'h0001);
    start_packet(16'h1236, 8'h00); add_bytes(1); send_packet(16'h0001);
  endtask

  task automatic test_truncation();
    // ends before function code, short request, odd count, mid-packet restart
    start_packet(16'h4444, 8'h01);
    pkt_q.pop_back(); pkt_q.pop_back();
    send_packet(16'h0002);
    start_packet(16'h5555, 8'h02); add_bytes(1); send_packet(16'h0002);
    start_packet(16'h5555, 8'h02); pkt_q.push_back(8'd3); add_bytes(5);
    send_packet(16'h0002);
    start_packet(16'h6666, 8'h0f); add_bytes(2); send_packet(16'h0003, 1'b1);
    start_packet(16'h6666, 8'h0f); add_bytes(3); send_packet(16'h0003);
  endtask

  task automatic test_long_packet();
    // position saturates; the tail is ignored
    start_packet(16'h7777, 8'h04); add_bytes(520); send_packet(16'h0004);
  endtask

  task automatic test_table_full();
    // more requests than cells, then answer them all
    steady = 1'b1;
    for (int n = 0; n < 18; n++) send_request(16'h0005, 16'(16'h0100 + n));
    steady = 1'b0;
    drain_fields();
    while (open_flow.size() != 0) send_response(0);
  endtask

  task automatic test_random_traffic();
    int unsigned pick;
    int unsigned stop_at;
    stop_at = items_sent + 450;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 15) == 0) steady = !steady;
      pick = $urandom_range(0, 9);
      if (open_flow.size() > 12 || (pick < 4 && open_flow.size() != 0)) begin
        send_response($urandom_range(0, open_flow.size() - 1));
      end else if (pick < 8) begin
        send_request(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3)),
                     ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 3)));
      end else begin
        // noise: random function code and length, sometimes left open
        start_packet(16'($urandom), 8'($urandom));
        add_bytes($urandom_range(0, 10));
        if ($urandom_range(0, 2) == 0) void'(pkt_q.pop_front());
        send_packet(16'($urandom_range(0, 3)), $urandom_range(0, 4) == 0);
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    errors      = 0;
    items_sent  = 0;
    steady      = 1'b0;
    pos_q = '0; tid_q = '0; func_q = '0; resp_q = 1'b0;
    mstart_q = '0; count_q = '0; held_q = '0; cap_q = '0;
    for (int e = 0; e < 16; e++) pend_valid[e] = 1'b0;
    rst_ni <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_function_codes();
    test_truncation();
    test_long_packet();
    test_table_full();
    drain_fields();
    test_random_traffic();

    drain_fields();
    repeat (10) @(posedge clk_i);
    if (errors == 0 && field_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (field_q.size() != 0) report($sformatf("%0d records missing", field_q.size()));
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
